// File: rtl/core/ihw_pkg.sv
// Shared types and constants for the ISO base media box header walker.
// Used by ihw_step and iso_box_header_walker_core; no dependencies.
package ihw_pkg;

	localparam int unsigned PosW   = 64;
	localparam int unsigned WordW  = 32;
	localparam int unsigned HdrW   = 5;

	localparam logic [WordW-1:0] TypeUuid = 32'h7575_6964;
	localparam logic [WordW-1:0] TypeFree = 32'h6672_6565;
	localparam logic [WordW-1:0] TypeSkip = 32'h736B_6970;

	localparam logic [HdrW-1:0] HdrBase = 5'd8;
	localparam logic [HdrW-1:0] HdrExt  = 5'd16;
	localparam logic [HdrW-1:0] HdrUuid = 5'd24;

	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_CONTENT = 3'd1,
		PH_DONE    = 3'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_SHORT_HDR  = 3'd1,
		ST_SHORT_UUID = 3'd2,
		ST_SHORT_EXT  = 3'd3,
		ST_BAD_SIZE   = 3'd4,
		ST_BAD_EXT    = 3'd5,
		ST_TRIMMED    = 3'd6
	} status_t;

	// walk state; rem is the byte count left from box_start to the limit
	typedef struct packed {
		logic [PosW-1:0]  pos;
		logic [PosW-1:0]  box_start;
		logic [PosW-1:0]  rem;
		phase_t           phase;
		logic [HdrW-1:0]  header_count;
		logic [WordW-1:0] size_word;
		logic [WordW-1:0] type_word;
		logic [PosW-1:0]  ext_size;
		logic [PosW-1:0]  uuid_hi;
		logic [PosW-1:0]  uuid_lo;
		logic [PosW-1:0]  content_left;
	} ihw_state_t;

	typedef struct packed {
		logic             valid;
		logic [PosW-1:0]  box_offset;
		logic [WordW-1:0] box_type;
		logic [HdrW-1:0]  header_bytes;
		logic [PosW-1:0]  content_bytes;
		logic [PosW-1:0]  uuid_high;
		logic [PosW-1:0]  uuid_low;
		logic             is_free_space;
		status_t          status;
	} ihw_result_t;

endpackage

// File: rtl/core/ihw_step.sv
// One byte of the box walk: next walk state and the optional box result.
// Combinational; depends on ihw_pkg.
module ihw_step (
	input  ihw_pkg::ihw_state_t  cur_state,
	input  logic [63:0]          stream_length,
	input  logic [7:0]           data_byte,
	input  logic                 stream_start,
	output ihw_pkg::ihw_state_t  nxt_state,
	output ihw_pkg::ihw_result_t result
);
	import ihw_pkg::*;

	ihw_state_t       cur;
	logic [WordW-1:0] sw;
	logic [WordW-1:0] tw;
	logic [PosW-1:0]  ex;
	logic [PosW-1:0]  u0;
	logic [PosW-1:0]  u1;
	logic [HdrW-1:0]  n1;
	logic             fin;
	logic             trunc;
	logic             with_uuid;
	logic [HdrW-1:0]  hdr;
	logic [PosW-1:0]  total;
	status_t          code;
	logic [PosW:0]    diff;
	logic             trim;
	logic [PosW-1:0]  content;

	always_comb begin
		// restart clears the walk before this byte is looked at
		if (stream_start) begin
			cur       = '0;
			cur.phase = PH_HEADER;
			cur.rem   = stream_length;
		end else begin
			cur = cur_state;
		end

		nxt_state = cur;
		if (cur.pos != {PosW{1'b1}}) begin
			nxt_state.pos = cur.pos + PosW'(1);
		end

		result    = '0;
		sw        = cur.size_word;
		tw        = cur.type_word;
		ex        = cur.ext_size;
		u0        = cur.uuid_hi;
		u1        = cur.uuid_lo;
		n1        = cur.header_count + HdrW'(1);
		fin       = 1'b0;
		trunc     = 1'b0;
		with_uuid = 1'b0;
		hdr       = HdrBase;
		total     = '0;
		code      = ST_OK;
		diff      = '0;
		trim      = 1'b0;
		content   = '0;

		if (cur.pos < stream_length) begin
			unique case (cur.phase)
				PH_CONTENT: begin
					if (cur.content_left != '0) begin
						nxt_state.content_left = cur.content_left - PosW'(1);
					end
					if (cur.content_left <= PosW'(1)) begin
						nxt_state.phase = (cur.rem != '0) ? PH_HEADER : PH_DONE;
					end
				end
				PH_HEADER: begin
					if (cur.header_count == '0 && cur.rem < PosW'(HdrBase)) begin
						// not even a basic header fits before the limit
						trunc = 1'b0;
						result.valid        = 1'b1;
						result.box_offset   = cur.box_start;
						result.box_type     = '0;
						result.header_bytes = cur.rem[HdrW-1:0];
						result.status       = ST_SHORT_HDR;
						nxt_state.phase     = PH_DONE;
					end else begin
						if (cur.header_count < HdrW'(4)) begin
							sw = {cur.size_word[WordW-9:0], data_byte};
						end else if (cur.header_count < HdrW'(8)) begin
							tw = {cur.type_word[WordW-9:0], data_byte};
						end else if (cur.header_count < HdrW'(16)) begin
							if (cur.size_word == WordW'(1)) begin
								ex = {cur.ext_size[PosW-9:0], data_byte};
							end else begin
								u0 = {cur.uuid_hi[PosW-9:0], data_byte};
							end
						end else begin
							u1 = {cur.uuid_lo[PosW-9:0], data_byte};
						end

						if (n1 == HdrBase) begin
							if (sw >= WordW'(8)) begin
								if (tw == TypeUuid) begin
									if (cur.rem < PosW'(HdrUuid)) begin
										trunc = 1'b1;
										code  = ST_SHORT_UUID;
									end else begin
										u0 = '0;
										u1 = '0;
									end
								end else begin
									fin   = 1'b1;
									total = PosW'(sw);
								end
							end else if (sw == '0) begin
								// runs to the limit
								fin   = 1'b1;
								total = cur.rem;
							end else if (sw != WordW'(1)) begin
								fin   = 1'b1;
								total = PosW'(HdrBase);
								code  = ST_BAD_SIZE;
							end else if (cur.rem < PosW'(HdrExt)) begin
								trunc = 1'b1;
								code  = ST_SHORT_EXT;
							end else begin
								ex = '0;
							end
						end else if (n1 == HdrExt && sw == WordW'(1)) begin
							fin = 1'b1;
							hdr = HdrExt;
							if (ex < PosW'(HdrExt)) begin
								total = PosW'(HdrExt);
								code  = ST_BAD_EXT;
							end else begin
								total = ex;
							end
						end else if (n1 >= HdrUuid) begin
							fin       = 1'b1;
							hdr       = HdrUuid;
							with_uuid = 1'b1;
							if (sw < WordW'(HdrUuid)) begin
								total = PosW'(HdrUuid);
								code  = ST_BAD_SIZE;
							end else begin
								total = PosW'(sw);
							end
						end

						nxt_state.size_word    = sw;
						nxt_state.type_word    = tw;
						nxt_state.ext_size     = ex;
						nxt_state.uuid_hi      = u0;
						nxt_state.uuid_lo      = u1;
						nxt_state.header_count = n1;

						// trimming: borrow of rem - total says the box overruns
						diff    = {1'b0, cur.rem} - {1'b0, total};
						trim    = diff[PosW];
						content = trim ? (cur.rem - PosW'(hdr)) : (total - PosW'(hdr));

						if (trunc) begin
							result.valid        = 1'b1;
							result.box_offset   = cur.box_start;
							result.box_type     = tw;
							result.header_bytes = cur.rem[HdrW-1:0];
							result.status       = code;
							nxt_state.phase     = PH_DONE;
						end else if (fin) begin
							result.valid         = 1'b1;
							result.box_offset    = cur.box_start;
							result.box_type      = tw;
							result.header_bytes  = hdr;
							result.content_bytes = content;
							result.uuid_high     = with_uuid ? u0 : '0;
							result.uuid_low      = with_uuid ? u1 : '0;
							result.status        = trim ? ST_TRIMMED : code;
							nxt_state.header_count = '0;
							nxt_state.content_left = content;
							nxt_state.rem          = trim ? '0 : diff[PosW-1:0];
							nxt_state.box_start    = trim ? stream_length
							                               : cur.box_start + total;
							if (content != '0) begin
								nxt_state.phase = PH_CONTENT;
							end else if (!trim && diff[PosW-1:0] != '0) begin
								nxt_state.phase = PH_HEADER;
							end else begin
								nxt_state.phase = PH_DONE;
							end
						end
					end
				end
				default: ;
			endcase
		end

		result.is_free_space = (result.box_type == TypeFree) || (result.box_type == TypeSkip);
	end

endmodule

// File: rtl/core/iso_box_header_walker_core.sv
// Top level of the ISO base media box header walker.
// Depends on ihw_pkg and ihw_step.
// A byte is held in the input register; its result is then held in the result register.
// Throughput: one byte per cycle while no result stalls; the walk step is combinational.
// in_stall rises only while a byte waits in the input register behind a stalled result.
// Reset (arst_n low) clears the walk, the limit and both valid flags at once; no clearing pass.
module iso_box_header_walker_core (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: stream length, the walk limit
	input  logic        cfg_write_en,
	input  logic [63:0] cfg_write_data,
	// byte channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        stream_start,
	// box result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] box_offset,
	output logic [31:0] box_type,
	output logic [4:0]  header_bytes,
	output logic [63:0] content_bytes,
	output logic [63:0] uuid_high,
	output logic [63:0] uuid_low,
	output logic        is_free_space,
	output logic [2:0]  status
);
	import ihw_pkg::*;

	// limit and walk state
	logic [PosW-1:0] stream_length_q;
	ihw_state_t      walk_q;

	// input register
	logic            item_valid_s1;
	logic [7:0]      data_byte_s1;
	logic            stream_start_s1;

	// result register
	logic            out_valid_q;
	ihw_result_t     res_q;

	ihw_state_t      walk_nxt;
	ihw_result_t     res_nxt;
	logic            in_take;
	logic            advance;
	logic            out_take;
	logic [PosW-1:0] cfg_rem;

	// the held byte may only move on once the result register can take its result
	assign out_take = out_valid_q && !out_stall;
	assign advance  = item_valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = item_valid_s1 && out_valid_q && out_stall;
	assign in_take  = in_valid && !in_stall;

	// bytes left when the limit is rewritten: zero once the box start reaches or lies beyond it
	assign cfg_rem = (cfg_write_data > walk_q.box_start) ? cfg_write_data - walk_q.box_start
	                                                     : '0;

	ihw_step u_step (
		.cur_state     (walk_q),
		.stream_length (stream_length_q),
		.data_byte     (data_byte_s1),
		.stream_start  (stream_start_s1),
		.nxt_state     (walk_nxt),
		.result        (res_nxt)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (in_take) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_byte_s1    <= data_byte;
			stream_start_s1 <= stream_start;
		end
	end

	// limit and walk state; configuration only arrives while no byte is in flight, which the user
	// must keep to: the block does not enforce it (all-zero walk state is the header phase at offset zero)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_length_q <= '0;
			walk_q          <= '0;
		end else begin
			if (cfg_write_en) begin
				stream_length_q <= cfg_write_data;
			end
			if (advance) begin
				walk_q <= walk_nxt;
			end else if (cfg_write_en) begin
				walk_q.rem <= cfg_rem;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_nxt.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_nxt.valid) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign box_offset    = res_q.box_offset;
	assign box_type      = res_q.box_type;
	assign header_bytes  = res_q.header_bytes;
	assign content_bytes = res_q.content_bytes;
	assign uuid_high     = res_q.uuid_high;
	assign uuid_low      = res_q.uuid_low;
	assign is_free_space = res_q.is_free_space;
	assign status        = res_q.status;

	// a truncated header ends the walk until the next restart
	a_trunc_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.valid && (res_nxt.status == ST_SHORT_HDR ||
		 res_nxt.status == ST_SHORT_UUID || res_nxt.status == ST_SHORT_EXT))
		|=> walk_q.phase == PH_DONE)
		else $error("walk did not stop after a truncated header");

	// content phase always has bytes left to skip
	a_content_left: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q.phase == PH_CONTENT |-> walk_q.content_left != '0)
		else $error("content phase with nothing left");

	// a clean box has one of the three header lengths
	a_ok_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.status == ST_OK) |->
		(res_q.header_bytes == HdrBase || res_q.header_bytes == HdrExt ||
		 res_q.header_bytes == HdrUuid))
		else $error("clean box with odd header length");

	// header collection never runs past the longest header
	a_hdr_count: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q.header_count <= HdrUuid)
		else $error("header count overran");

	// back-pressure on the byte side comes only from a stalled result
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && item_valid_s1))
		else $error("byte side stalled without a held result");

endmodule
